FILE: design/vector_normalize_2d_assert.svh
// assertion macros shared by the vector normalizer
`ifndef VECTOR_NORMALIZE_2D_ASSERT_SVH
`define VECTOR_NORMALIZE_2D_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VN2D_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define VN2D_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: design/vn2d_pkg.sv
// shared types and constants of the vector normalizer
package vn2d_pkg;

   // width of every component field on the ports
   localparam int FIELD_W = 16;
   localparam int UNIT_W  = 16;

   // input word: one vector
   typedef struct packed {
      logic signed [FIELD_W-1:0] x_in;
      logic signed [FIELD_W-1:0] y_in;
   } req_word_type;

   // result word: unit vector in fixed point plus failure flag
   typedef struct packed {
      logic signed [UNIT_W-1:0] x_unit;
      logic signed [UNIT_W-1:0] y_unit;
      logic                     zero_length;
   } rsp_word_type;

endpackage

FILE: design/vn2d_front.sv
// front stages: magnitudes, squares, length squared and starting remainders
module vn2d_front import vn2d_pkg::*; #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic                                     clock,
   input  logic                                     en_a,
   input  logic                                     en_b,
   input  req_word_type                             req_word,
   output logic [2*IN_WIDTH-1:0]                    s_ff,
   output logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] rx_ff,
   output logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] ry_ff,
   output logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] t_ff,
   output logic                                     nx_ff,
   output logic                                     ny_ff,
   output logic                                     zero_ff
);

   localparam int RAW_W = (IN_WIDTH > FIELD_W) ? IN_WIDTH : FIELD_W;
   localparam int SQ_W  = 2*IN_WIDTH - 1;
   localparam int S_W   = 2*IN_WIDTH;
   localparam int ACC_W = 2*IN_WIDTH + 2*FRAC_BITS + 5;

   logic [RAW_W-1:0]      raw_x;
   logic [RAW_W-1:0]      raw_y;
   logic [IN_WIDTH-1:0]   vx;
   logic [IN_WIDTH-1:0]   vy;
   logic                  nx_in;
   logic                  ny_in;
   logic [IN_WIDTH-1:0]   mx;
   logic [IN_WIDTH-1:0]   my;
   logic [2*IN_WIDTH-1:0] prod_x;
   logic [2*IN_WIDTH-1:0] prod_y;
   logic [SQ_W-1:0]       sqx_ff;
   logic [SQ_W-1:0]       sqy_ff;
   logic                  nxa_ff;
   logic                  nya_ff;
   logic [S_W-1:0]        s_in;
   logic [ACC_W-1:0]      sqx_ext;
   logic [ACC_W-1:0]      sqy_ext;
   logic signed [ACC_W-1:0] rx_in;
   logic signed [ACC_W-1:0] ry_in;
   logic signed [ACC_W-1:0] t_in;
   logic                  zero_in;

   // field bits above the input width are dropped, then sign is taken
   assign raw_x = RAW_W'(unsigned'(req_word.x_in));
   assign raw_y = RAW_W'(unsigned'(req_word.y_in));
   assign vx    = raw_x[IN_WIDTH-1:0];
   assign vy    = raw_y[IN_WIDTH-1:0];
   assign nx_in = vx[IN_WIDTH-1];
   assign ny_in = vy[IN_WIDTH-1];
   assign mx    = nx_in ? (-vx) : vx;
   assign my    = ny_in ? (-vy) : vy;

   // squares of the magnitudes
   assign prod_x = mx * mx;
   assign prod_y = my * my;

   always_ff @(posedge clock) begin
      if (en_a) begin
         sqx_ff <= prod_x[SQ_W-1:0];
         sqy_ff <= prod_y[SQ_W-1:0];
         nxa_ff <= nx_in;
         nya_ff <= ny_in;
      end
   end

   // length squared, remainder 4*m^2*2^(2f) - s, and first trial term (2^f - 1)*s
   assign sqx_ext = ACC_W'(sqx_ff);
   assign sqy_ext = ACC_W'(sqy_ff);
   assign s_in    = S_W'(sqx_ff) + S_W'(sqy_ff);
   assign rx_in   = (sqx_ext << (2*FRAC_BITS + 2)) - sqx_ext - sqy_ext;
   assign ry_in   = (sqy_ext << (2*FRAC_BITS + 2)) - sqx_ext - sqy_ext;
   assign t_in    = (sqx_ext << FRAC_BITS) + (sqy_ext << FRAC_BITS) - sqx_ext - sqy_ext;
   assign zero_in = (sqx_ff == '0) && (sqy_ff == '0);

   always_ff @(posedge clock) begin
      if (en_b) begin
         s_ff    <= s_in;
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         t_ff    <= t_in;
         nx_ff   <= nxa_ff;
         ny_ff   <= nya_ff;
         zero_ff <= zero_in;
      end
   end

endmodule

FILE: design/vn2d_cell.sv
// one cell of the quotient chain: settles one result bit of one component
module vn2d_cell #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 14,
   parameter int BIT       = 14
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic [2*IN_WIDTH-1:0]                    s_prev,
   input  logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] r_prev,
   input  logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] t_prev,
   input  logic [FRAC_BITS:0]                       q_prev,
   input  logic                                     neg_prev,
   output logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] r_ff,
   output logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] t_ff,
   output logic [FRAC_BITS:0]                       q_ff,
   output logic                                     neg_ff
);

   localparam int ACC_W = 2*IN_WIDTH + 2*FRAC_BITS + 5;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam logic [Q_W-1:0] BIT_MASK = Q_W'(1) << BIT;

   logic signed [ACC_W-1:0] delta;
   logic signed [ACC_W-1:0] diff;
   logic signed [ACC_W-1:0] r_in;
   logic signed [ACC_W-1:0] t_in;
   logic [Q_W-1:0]          q_in;
   logic                    take;

   // trial: raising the odd multiple by 2^(b+1) costs 2^(b+2) * t
   assign delta = t_prev <<< (BIT + 2);
   assign diff  = r_prev - delta;
   // a quotient already at full scale takes no more bits
   assign take  = !q_prev[Q_W-1] && !diff[ACC_W-1];
   assign r_in  = take ? diff : r_prev;
   assign q_in  = take ? (q_prev | BIT_MASK) : q_prev;

   // trial term for the next lower bit
   generate
      if (BIT > 0) begin : g_next
         logic signed [ACC_W-1:0] s_ext;
         assign s_ext = ACC_W'(s_prev);
         assign t_in  = take ? (t_prev + (s_ext <<< BIT) + (s_ext <<< (BIT - 1)))
                             : (t_prev - (s_ext <<< (BIT - 1)));
      end else begin : g_last
         assign t_in = t_prev;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff   <= r_in;
         t_ff   <= t_in;
         q_ff   <= q_in;
         neg_ff <= neg_prev;
      end
   end

endmodule

FILE: design/vector_normalize_2d.sv
// top level of the two-dimensional vector normalizer
//
// req channel carries one vector (x_in, y_in) per word; rsp channel returns
// the unit vector in fixed point with FRAC_BITS fraction bits, rounded to
// nearest with ties away from zero, and zero_length for a zero vector (then
// both components are zero). Both channels move a word at a clock edge where
// valid is high and stall is low.
// The datapath is a pipeline of FRAC_BITS + 4 stages: magnitudes and squares,
// length squared, one pair of cells per result bit (FRAC_BITS + 1 pairs, each
// pair doing one compare and subtract for x and for y), and the output register.
// Throughput is one word per clock while rsp is not stalled. Under rsp_stall
// the stages squeeze out their empty slots, so req_stall rises only when every
// stage holds a word. Reset clears the stage valid bits only; there is no
// stored table and no clearing pass.
`include "vector_normalize_2d_assert.svh"

module vector_normalize_2d import vn2d_pkg::*; #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int S_W   = 2*IN_WIDTH;
   localparam int ACC_W = 2*IN_WIDTH + 2*FRAC_BITS + 5;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int NCELL = FRAC_BITS + 1;
   localparam int NS    = FRAC_BITS + 4;
   localparam int OUT_W = (Q_W + 1 > UNIT_W) ? Q_W + 1 : UNIT_W;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] en;

   logic [S_W-1:0]          s_chain  [0:NCELL-1];
   logic signed [ACC_W-1:0] rx_chain [0:NCELL];
   logic signed [ACC_W-1:0] ry_chain [0:NCELL];
   logic signed [ACC_W-1:0] tx_chain [0:NCELL];
   logic signed [ACC_W-1:0] ty_chain [0:NCELL];
   logic [Q_W-1:0]          qx_chain [0:NCELL];
   logic [Q_W-1:0]          qy_chain [0:NCELL];
   logic                    nx_chain [0:NCELL];
   logic                    ny_chain [0:NCELL];
   logic                    zero_chain [0:NCELL];
   logic signed [ACC_W-1:0] t_first;

   logic [OUT_W-1:0] qx_ext;
   logic [OUT_W-1:0] qy_ext;
   logic [OUT_W-1:0] ux;
   logic [OUT_W-1:0] uy;
   rsp_word_type     rsp_word_in;
   rsp_word_type     rsp_word_ff;

   // a stage may load when it or any stage after it is empty, or rsp drains
   generate
      for (genvar k = 0; k < NS; k++) begin : g_en
         assign en[k] = !rsp_stall || !(&v_ff[NS-1:k]);
      end
   endgenerate

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NS-1];

   // stage valid bits
   always_comb begin
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // magnitudes, squares and starting remainders
   vn2d_front #(
      .IN_WIDTH  (IN_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .en_a     (en[0]),
      .en_b     (en[1]),
      .req_word (req_word),
      .s_ff     (s_chain[0]),
      .rx_ff    (rx_chain[0]),
      .ry_ff    (ry_chain[0]),
      .t_ff     (t_first),
      .nx_ff    (nx_chain[0]),
      .ny_ff    (ny_chain[0]),
      .zero_ff  (zero_chain[0])
   );

   assign tx_chain[0] = t_first;
   assign ty_chain[0] = t_first;
   assign qx_chain[0] = '0;
   assign qy_chain[0] = '0;

   // chain of cells, most significant result bit first
   generate
      for (genvar i = 0; i < NCELL; i++) begin : g_cell
         vn2d_cell #(
            .IN_WIDTH  (IN_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .BIT       (FRAC_BITS - i)
         ) u_cell_x (
            .clock    (clock),
            .en       (en[2+i]),
            .s_prev   (s_chain[i]),
            .r_prev   (rx_chain[i]),
            .t_prev   (tx_chain[i]),
            .q_prev   (qx_chain[i]),
            .neg_prev (nx_chain[i]),
            .r_ff     (rx_chain[i+1]),
            .t_ff     (tx_chain[i+1]),
            .q_ff     (qx_chain[i+1]),
            .neg_ff   (nx_chain[i+1])
         );

         vn2d_cell #(
            .IN_WIDTH  (IN_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .BIT       (FRAC_BITS - i)
         ) u_cell_y (
            .clock    (clock),
            .en       (en[2+i]),
            .s_prev   (s_chain[i]),
            .r_prev   (ry_chain[i]),
            .t_prev   (ty_chain[i]),
            .q_prev   (qy_chain[i]),
            .neg_prev (ny_chain[i]),
            .r_ff     (ry_chain[i+1]),
            .t_ff     (ty_chain[i+1]),
            .q_ff     (qy_chain[i+1]),
            .neg_ff   (ny_chain[i+1])
         );

         // length squared and zero flag travel beside the cells
         always_ff @(posedge clock) begin
            if (en[2+i]) begin
               zero_chain[i+1] <= zero_chain[i];
            end
         end

         if (i < NCELL - 1) begin : g_s
            always_ff @(posedge clock) begin
               if (en[2+i]) begin
                  s_chain[i+1] <= s_chain[i];
               end
            end
         end
      end
   endgenerate

   // sign applied to the quotient, zero vector forced to zero
   assign qx_ext = OUT_W'(qx_chain[NCELL]);
   assign qy_ext = OUT_W'(qy_chain[NCELL]);
   assign ux     = nx_chain[NCELL] ? (-qx_ext) : qx_ext;
   assign uy     = ny_chain[NCELL] ? (-qy_ext) : qy_ext;

   always_comb begin
      rsp_word_in.x_unit      = zero_chain[NCELL] ? '0 : signed'(ux[UNIT_W-1:0]);
      rsp_word_in.y_unit      = zero_chain[NCELL] ? '0 : signed'(uy[UNIT_W-1:0]);
      rsp_word_in.zero_length = zero_chain[NCELL];
   end

   // output register
   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_word = rsp_word_ff;

   // checks on the pipeline control and the result
   `VN2D_ASSERT_IMPLY(a_zero_out, clock, reset, rsp_valid && rsp_word.zero_length, rsp_word.x_unit == '0 && rsp_word.y_unit == '0, "zero vector gave nonzero result")
   `VN2D_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, v_ff[0], "accepted word did not enter the first stage")
   `VN2D_ASSERT_IMPLY(a_stall_full, clock, reset, req_stall, (&v_ff) && rsp_stall, "req stalled while a stage was empty")

endmodule
